// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/exl_pkg.sv =====
// types, token kind codes and helpers for the expression text lexer
// depends on nothing
`default_nettype none
package exl_pkg;
   localparam int POS_W   = 16;
   localparam int MAX_TOK = 4;
   localparam int CNT_W   = $clog2(MAX_TOK + 1);

   localparam logic [4:0] K_ILLEGAL = 5'd0;
   localparam logic [4:0] K_END     = 5'd1;
   localparam logic [4:0] K_IDENT   = 5'd2;
   localparam logic [4:0] K_INT     = 5'd3;
   localparam logic [4:0] K_FLOAT   = 5'd4;
   localparam logic [4:0] K_STRING  = 5'd5;
   localparam logic [4:0] K_ASSIGN  = 5'd6;
   localparam logic [4:0] K_EQ      = 5'd7;
   localparam logic [4:0] K_LPAREN  = 5'd8;
   localparam logic [4:0] K_RPAREN  = 5'd9;
   localparam logic [4:0] K_COMMA   = 5'd10;
   localparam logic [4:0] K_PLUS    = 5'd11;
   localparam logic [4:0] K_MINUS   = 5'd12;
   localparam logic [4:0] K_LBRACK  = 5'd13;
   localparam logic [4:0] K_RBRACK  = 5'd14;
   localparam logic [4:0] K_SLASH   = 5'd15;
   localparam logic [4:0] K_STAR    = 5'd16;
   localparam logic [4:0] K_POW     = 5'd17;
   localparam logic [4:0] K_BANG    = 5'd18;
   localparam logic [4:0] K_NE      = 5'd19;
   localparam logic [4:0] K_LT      = 5'd20;
   localparam logic [4:0] K_LE      = 5'd21;
   localparam logic [4:0] K_GT      = 5'd22;
   localparam logic [4:0] K_GE      = 5'd23;
   localparam logic [4:0] K_COLON   = 5'd24;
   localparam logic [4:0] K_DOT     = 5'd25;

   typedef struct packed {
      logic [4:0]       kind;
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] off;
      logic [POS_W-1:0] len;
      logic             last;
   } tok_type;

   typedef tok_type [MAX_TOK-1:0] tok_set_type;

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic ident_start(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic ident_char(input logic [7:0] c);
      return ident_start(c) || is_digit(c);
   endfunction

   function automatic tok_type mk_tok(input logic [4:0] kind, input logic [POS_W-1:0] line,
                                      input logic [POS_W-1:0] col,
                                      input logic [POS_W-1:0] off,
                                      input logic [POS_W-1:0] len);
      tok_type t;
      t.kind = kind;
      t.line = line;
      t.col  = col;
      t.off  = off;
      t.len  = len;
      t.last = 1'b0;
      return t;
   endfunction
endpackage
`default_nettype wire

// ===== sv/exl_if.sv =====
// valid/ready channel interfaces for text bytes and token records
// depends on exl_pkg
`default_nettype none
interface exl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface exl_rsp_if import exl_pkg::*;;
   logic             valid;
   logic             ready;
   logic [4:0]       token_kind;
   logic [POS_W-1:0] first_line;
   logic [POS_W-1:0] first_column;
   logic [POS_W-1:0] start_offset;
   logic [POS_W-1:0] lexeme_length;
   logic             last_of_run;
   modport source (output valid, token_kind, first_line, first_column, start_offset,
                   lexeme_length, last_of_run, input ready);
   modport sink (input valid, token_kind, first_line, first_column, start_offset,
                 lexeme_length, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/exl_scan.sv =====
// lexer state registers and combinational scan logic for one text byte
// depends on exl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module exl_scan import exl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  text_byte,
   input  wire logic        end_of_text,
   output tok_set_type      toks,
   output logic [CNT_W-1:0] tok_cnt
);
   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_IDENT  = 4'd1;
   localparam logic [3:0] M_NUM    = 4'd2;
   localparam logic [3:0] M_NUM_E  = 4'd3;
   localparam logic [3:0] M_NUM_EP = 4'd4;
   localparam logic [3:0] M_NUM_EM = 4'd5;
   localparam logic [3:0] M_EXP    = 4'd6;
   localparam logic [3:0] M_STR    = 4'd7;
   localparam logic [3:0] M_DOT    = 4'd8;
   localparam logic [3:0] M_EQ     = 4'd9;
   localparam logic [3:0] M_STAR   = 4'd10;
   localparam logic [3:0] M_BANG   = 4'd11;
   localparam logic [3:0] M_LT     = 4'd12;
   localparam logic [3:0] M_GT     = 4'd13;

   localparam logic [POS_W-1:0] ONE = POS_W'(1);

   logic [3:0]       mode_ff, mode_in;
   logic             quote_ff, quote_in;
   logic             dot_ff, dot_in;
   logic [POS_W-1:0] ts_off_ff, ts_off_in, ts_line_ff, ts_line_in, ts_col_ff, ts_col_in;
   logic [POS_W-1:0] hm_off_ff, hm_off_in, hm_line_ff, hm_line_in, hm_col_ff, hm_col_in;
   logic [POS_W-1:0] off_ff, off_in, line_ff, line_in, col_ff, col_in;
   logic [POS_W-1:0] len_ff, len_in;

   logic       is_end;
   logic [7:0] quote_byte;
   assign is_end     = end_of_text || (text_byte == 8'h00);
   assign quote_byte = quote_ff ? 8'h27 : 8'h22;

   // pending token, then fresh byte, then position update
   always_comb begin
      logic [CNT_W-1:0] n;
      logic             used;
      logic             is_op;
      logic [7:0]       second;
      logic [4:0]       k1, k2, num_kind;
      n = '0;
      used = 1'b0;
      is_op = 1'b0;
      second = 8'h00;
      k1 = K_ILLEGAL;
      k2 = K_ILLEGAL;
      num_kind = dot_ff ? K_FLOAT : K_INT;
      toks = '0;
      mode_in = mode_ff;
      quote_in = quote_ff;
      dot_in = dot_ff;
      ts_off_in = ts_off_ff;
      ts_line_in = ts_line_ff;
      ts_col_in = ts_col_ff;
      hm_off_in = hm_off_ff;
      hm_line_in = hm_line_ff;
      hm_col_in = hm_col_ff;
      off_in = off_ff;
      line_in = line_ff;
      col_in = col_ff;
      len_in = len_ff;

      case (mode_ff)
         M_IDENT: begin
            if (!is_end && ident_char(text_byte)) begin
               len_in = sat_add(len_ff, ONE);
               used = 1'b1;
            end else begin
               toks[n[1:0]] = mk_tok(K_IDENT, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               mode_in = M_IDLE;
            end
         end
         M_NUM: begin
            if (!is_end && is_digit(text_byte)) begin
               len_in = sat_add(len_ff, ONE);
               used = 1'b1;
            end else if (!is_end && text_byte == "." && !dot_ff) begin
               dot_in = 1'b1;
               len_in = sat_add(len_ff, ONE);
               used = 1'b1;
            end else if (!is_end && (text_byte == "e" || text_byte == "E")) begin
               hm_off_in = off_ff;
               hm_line_in = line_ff;
               hm_col_in = col_ff;
               mode_in = M_NUM_E;
               used = 1'b1;
            end else begin
               toks[n[1:0]] = mk_tok(num_kind, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               mode_in = M_IDLE;
            end
         end
         M_NUM_E: begin
            if (!is_end && is_digit(text_byte)) begin
               len_in = sat_add(len_ff, POS_W'(2));
               mode_in = M_EXP;
               used = 1'b1;
            end else if (!is_end && text_byte == "+") begin
               mode_in = M_NUM_EP;
               used = 1'b1;
            end else if (!is_end && text_byte == "-") begin
               mode_in = M_NUM_EM;
               used = 1'b1;
            end else begin
               toks[n[1:0]] = mk_tok(num_kind, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               if (!is_end && ident_char(text_byte)) begin
                  // identifier starts at the held marker
                  ts_off_in = hm_off_ff;
                  ts_line_in = hm_line_ff;
                  ts_col_in = hm_col_ff;
                  len_in = POS_W'(2);
                  mode_in = M_IDENT;
                  used = 1'b1;
               end else begin
                  toks[n[1:0]] = mk_tok(K_IDENT, hm_line_ff, hm_col_ff, hm_off_ff, ONE);
                  n = n + 1'b1;
                  mode_in = M_IDLE;
               end
            end
         end
         M_NUM_EP, M_NUM_EM: begin
            if (!is_end && is_digit(text_byte)) begin
               len_in = sat_add(len_ff, POS_W'(3));
               mode_in = M_EXP;
               used = 1'b1;
            end else begin
               // rejected exponent: number, marker, sign
               toks[n[1:0]] = mk_tok(num_kind, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               toks[n[1:0]] = mk_tok(K_IDENT, hm_line_ff, hm_col_ff, hm_off_ff, ONE);
               n = n + 1'b1;
               toks[n[1:0]] = mk_tok((mode_ff == M_NUM_EP) ? K_PLUS : K_MINUS, hm_line_ff,
                                     sat_add(hm_col_ff, ONE), hm_off_ff + ONE, ONE);
               n = n + 1'b1;
               mode_in = M_IDLE;
            end
         end
         M_EXP: begin
            if (!is_end && is_digit(text_byte)) begin
               len_in = sat_add(len_ff, ONE);
               used = 1'b1;
            end else begin
               toks[n[1:0]] = mk_tok(K_FLOAT, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               mode_in = M_IDLE;
            end
         end
         M_STR: begin
            if (is_end) begin
               toks[n[1:0]] = mk_tok(K_ILLEGAL, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               mode_in = M_IDLE;
            end else if (text_byte == quote_byte) begin
               toks[n[1:0]] = mk_tok(K_STRING, ts_line_ff, ts_col_ff, ts_off_ff, len_ff);
               n = n + 1'b1;
               mode_in = M_IDLE;
               used = 1'b1;
            end else begin
               len_in = sat_add(len_ff, ONE);
               used = 1'b1;
            end
         end
         M_DOT: begin
            if (!is_end && is_digit(text_byte)) begin
               dot_in = 1'b1;
               len_in = POS_W'(2);
               mode_in = M_NUM;
               used = 1'b1;
            end else begin
               toks[n[1:0]] = mk_tok(K_DOT, ts_line_ff, ts_col_ff, ts_off_ff, ONE);
               n = n + 1'b1;
               mode_in = M_IDLE;
            end
         end
         M_EQ: begin
            is_op = 1'b1; second = "="; k1 = K_ASSIGN; k2 = K_EQ;
         end
         M_STAR: begin
            is_op = 1'b1; second = "*"; k1 = K_STAR; k2 = K_POW;
         end
         M_BANG: begin
            is_op = 1'b1; second = "="; k1 = K_BANG; k2 = K_NE;
         end
         M_LT: begin
            is_op = 1'b1; second = "="; k1 = K_LT; k2 = K_LE;
         end
         M_GT: begin
            is_op = 1'b1; second = "="; k1 = K_GT; k2 = K_GE;
         end
         default: begin
            mode_in = M_IDLE;
         end
      endcase

      // one- or two-character operator lookahead
      if (is_op) begin
         mode_in = M_IDLE;
         if (!is_end && text_byte == second) begin
            toks[n[1:0]] = mk_tok(k2, ts_line_ff, ts_col_ff, ts_off_ff, POS_W'(2));
            used = 1'b1;
         end else begin
            toks[n[1:0]] = mk_tok(k1, ts_line_ff, ts_col_ff, ts_off_ff, ONE);
         end
         n = n + 1'b1;
      end

      if (is_end) begin
         // end of text: emit end token and return to reset state
         toks[n[1:0]] = mk_tok(K_END, line_ff, col_ff, off_ff, '0);
         n = n + 1'b1;
         mode_in = M_IDLE;
         quote_in = 1'b0;
         dot_in = 1'b0;
         ts_off_in = '0;
         ts_line_in = ONE;
         ts_col_in = ONE;
         hm_off_in = '0;
         hm_line_in = '0;
         hm_col_in = '0;
         off_in = '0;
         line_in = ONE;
         col_in = ONE;
         len_in = '0;
      end else begin
         // fresh byte between tokens
         if (!used) begin
            case (text_byte)
               "(", ")", ",", "+", "-", "[", "]", "/", ":": begin
                  case (text_byte)
                     "(":     k1 = K_LPAREN;
                     ")":     k1 = K_RPAREN;
                     ",":     k1 = K_COMMA;
                     "+":     k1 = K_PLUS;
                     "-":     k1 = K_MINUS;
                     "[":     k1 = K_LBRACK;
                     "]":     k1 = K_RBRACK;
                     "/":     k1 = K_SLASH;
                     default: k1 = K_COLON;
                  endcase
                  toks[n[1:0]] = mk_tok(k1, line_ff, col_ff, off_ff, ONE);
                  n = n + 1'b1;
               end
               "=", "*", "!", "<", ">", ".": begin
                  ts_off_in = off_ff;
                  ts_line_in = line_ff;
                  ts_col_in = col_ff;
                  case (text_byte)
                     "=":     mode_in = M_EQ;
                     "*":     mode_in = M_STAR;
                     "!":     mode_in = M_BANG;
                     "<":     mode_in = M_LT;
                     ">":     mode_in = M_GT;
                     default: mode_in = M_DOT;
                  endcase
               end
               8'h22, 8'h27: begin
                  ts_off_in = off_ff + ONE;
                  ts_line_in = line_ff;
                  ts_col_in = col_ff;
                  quote_in = (text_byte == 8'h27);
                  len_in = '0;
                  mode_in = M_STR;
               end
               default: begin
                  if (text_byte == " " || (text_byte inside {[8'd9:8'd13]})) begin
                     // whitespace skipped
                  end else if (ident_start(text_byte)) begin
                     ts_off_in = off_ff;
                     ts_line_in = line_ff;
                     ts_col_in = col_ff;
                     len_in = ONE;
                     mode_in = M_IDENT;
                  end else if (is_digit(text_byte)) begin
                     ts_off_in = off_ff;
                     ts_line_in = line_ff;
                     ts_col_in = col_ff;
                     len_in = ONE;
                     dot_in = 1'b0;
                     mode_in = M_NUM;
                  end else begin
                     toks[n[1:0]] = mk_tok(K_ILLEGAL, line_ff, col_ff, off_ff, ONE);
                     n = n + 1'b1;
                  end
               end
            endcase
         end
         // position tracking
         if (text_byte == 8'h0a) begin
            line_in = sat_add(line_ff, ONE);
            col_in = ONE;
         end else begin
            col_in = sat_add(col_ff, ONE);
         end
         off_in = off_ff + ONE;
      end

      if (n != '0) begin
         toks[2'(n - 1'b1)].last = 1'b1;
      end
      tok_cnt = n;
   end

   // state registers advance once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         quote_ff <= 1'b0;
         dot_ff <= 1'b0;
         ts_off_ff <= '0;
         ts_line_ff <= ONE;
         ts_col_ff <= ONE;
         hm_off_ff <= '0;
         hm_line_ff <= '0;
         hm_col_ff <= '0;
         off_ff <= '0;
         line_ff <= ONE;
         col_ff <= ONE;
         len_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         quote_ff <= quote_in;
         dot_ff <= dot_in;
         ts_off_ff <= ts_off_in;
         ts_line_ff <= ts_line_in;
         ts_col_ff <= ts_col_in;
         hm_off_ff <= hm_off_in;
         hm_line_ff <= hm_line_in;
         hm_col_ff <= hm_col_in;
         off_ff <= off_in;
         line_ff <= line_in;
         col_ff <= col_in;
         len_ff <= len_in;
      end
   end

   `ASSERT_NEXT(a_end_resets, clock, reset, accept && is_end, mode_ff == M_IDLE && off_ff == '0 && line_ff == ONE, "end of text did not reset lexer")
   `ASSERT_HOLDS(a_line_nonzero, clock, reset, line_ff != '0 && col_ff != '0, "line or column reached zero")
   `ASSERT_HOLDS(a_mode_range, clock, reset, mode_ff <= M_GT, "scan mode out of range")
endmodule
`default_nettype wire

// ===== sv/exl_outq.sv =====
// buffer of one transaction's token records, drained one per cycle while out_ready
// depends on exl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module exl_outq import exl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire tok_set_type toks,
   input  wire logic [CNT_W-1:0] tok_cnt,
   output logic             can_load,
   output logic             out_valid,
   input  wire logic        out_ready,
   output tok_type          out_tok
);
   tok_set_type                  tok_ff;
   logic [CNT_W-1:0]             rem_ff;
   logic [$clog2(MAX_TOK)-1:0]   rd_ff;

   assign out_valid = (rem_ff != '0);
   assign out_tok   = tok_ff[rd_ff];
   // accept a new set once the last record leaves
   assign can_load  = (rem_ff == '0) || ((rem_ff == CNT_W'(1)) && out_ready);

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= toks;
      end
   end

   // remaining count and read index
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         rd_ff <= '0;
      end else if (load) begin
         rem_ff <= tok_cnt;
         rd_ff <= '0;
      end else if (out_valid && out_ready) begin
         rem_ff <= rem_ff - 1'b1;
         rd_ff <= rd_ff + 1'b1;
      end
   end

   `ASSERT_HOLDS(a_rem_bound, clock, reset, rem_ff <= CNT_W'(MAX_TOK), "too many queued records")
   `ASSERT_HOLDS(a_last_flag, clock, reset, !out_valid || (out_tok.last == (rem_ff == CNT_W'(1))), "last flag not on final record")
   `ASSERT_NEXT(a_stall_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(rd_ff), "stalled record moved")
endmodule
`default_nettype wire

// ===== sv/expression_text_lexer_top.sv =====
// top level of the expression text lexer: scan logic and result buffer
// depends on exl_pkg, exl_if, exl_scan and exl_outq
//
//   channel   dir  payload                                          handshake
//   req_ch    in   text_byte, end_of_text                           valid/ready
//   rsp_ch    out  token_kind, first_line, first_column,           valid/ready
//                  start_offset, lexeme_length, last_of_run
//
// each text byte is scanned in the cycle it is accepted; its 0 to 4 records
// land in the result buffer and leave one per cycle while rsp_ch.ready is high
// a byte with at most one record sustains one transaction per cycle when rsp_ch is ready;
// a byte with more records holds req_ch.ready low until its last record is leaving (result buffer drain)
// synchronous active-high reset returns to line 1, column 1, offset 0
// a stalled rsp_ch holds its record and backs up into req_ch
`default_nettype none
module expression_text_lexer_top import exl_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   exl_req_if.sink  req_ch,
   exl_rsp_if.source rsp_ch
);
   tok_set_type      toks;
   logic [CNT_W-1:0] tok_cnt;
   logic             can_load;
   logic             accept;
   tok_type          out_tok;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   exl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_ch.text_byte),
      .end_of_text (req_ch.end_of_text),
      .toks        (toks),
      .tok_cnt     (tok_cnt)
   );

   exl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .toks      (toks),
      .tok_cnt   (tok_cnt),
      .can_load  (can_load),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_tok   (out_tok)
   );

   // result fields
   assign rsp_ch.token_kind    = out_tok.kind;
   assign rsp_ch.first_line    = out_tok.line;
   assign rsp_ch.first_column  = out_tok.col;
   assign rsp_ch.start_offset  = out_tok.off;
   assign rsp_ch.lexeme_length = out_tok.len;
   assign rsp_ch.last_of_run   = out_tok.last;
endmodule
`default_nettype wire

// ===== verif/expression_text_lexer_top_tb.sv =====
// testbench for the expression text lexer: random and directed text bytes,
// token records checked against a built-in scanner model
// depends on exl_pkg, exl_if and expression_text_lexer_top
`default_nettype none
module expression_text_lexer_top_tb;
   import exl_pkg::*;

   typedef enum logic [3:0] {
      SC_IDLE, SC_IDENT, SC_NUM, SC_NUM_E, SC_NUM_EP, SC_NUM_EM, SC_EXP, SC_STR,
      SC_DOT, SC_EQ, SC_STAR, SC_BANG, SC_LT, SC_GT
   } scan_state_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   typedef struct packed {
      logic [4:0]       kind;
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] off;
      logic [POS_W-1:0] len;
      logic             last;
   } token_rec_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   exl_req_if req_ch ();
   exl_rsp_if rsp_ch ();

   expression_text_lexer_top dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   text_item_type  text_queue[$];
   token_rec_type  token_queue[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          send_idle_ok = 1'b1;
   bit          recv_idle_ok = 1'b1;
   int          recv_hold = 0;

   // scanner model state
   scan_state_type   lx_mode;
   logic             lx_quote;
   logic             lx_dot;
   logic [POS_W-1:0] lx_tok_off, lx_tok_line, lx_tok_col;
   logic [POS_W-1:0] lx_e_off, lx_e_line, lx_e_col;
   logic [POS_W-1:0] lx_off, lx_line, lx_col, lx_len;
   token_rec_type    lx_out[$];

   function automatic logic [POS_W-1:0] add_sat(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = a + b;
      return s[POS_W] ? '1 : s[POS_W-1:0];
   endfunction

   function automatic bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit word_start_c(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   task automatic lexer_clear();
      lx_mode = SC_IDLE; lx_quote = 0; lx_dot = 0;
      lx_tok_off = 0; lx_tok_line = 1; lx_tok_col = 1;
      lx_e_off = 0; lx_e_line = 0; lx_e_col = 0;
      lx_off = 0; lx_line = 1; lx_col = 1; lx_len = 0;
   endtask

   function automatic void put_token(logic [4:0] k, logic [POS_W-1:0] ln,
                                     logic [POS_W-1:0] cl, logic [POS_W-1:0] of,
                                     logic [POS_W-1:0] le);
      token_rec_type t;
      t = '{k, ln, cl, of, le, 1'b0};
      if (lx_out.size() < 5) lx_out.push_back(t);
   endfunction

   task automatic mark_here();
      lx_tok_off = lx_off; lx_tok_line = lx_line; lx_tok_col = lx_col;
   endtask

   // pending token handling; returns 1 when the byte was consumed
   function automatic bit lex_pending(logic [7:0] c, bit fin);
      scan_state_type m;
      logic [7:0]  second;
      logic [4:0]  k1, k2;
      m = lx_mode; second = 0; k1 = 0; k2 = 0;
      case (m)
         SC_IDENT: begin
            if (!fin && (word_start_c(c) || digit_c(c))) begin
               lx_len = add_sat(lx_len, 1); return 1;
            end
            put_token(K_IDENT, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
         end
         SC_NUM: begin
            if (!fin && digit_c(c)) begin lx_len = add_sat(lx_len, 1); return 1; end
            if (!fin && c == "." && !lx_dot) begin
               lx_dot = 1; lx_len = add_sat(lx_len, 1); return 1;
            end
            if (!fin && (c == "e" || c == "E")) begin
               lx_e_off = lx_off; lx_e_line = lx_line; lx_e_col = lx_col;
               lx_mode = SC_NUM_E; return 1;
            end
            put_token(lx_dot ? K_FLOAT : K_INT, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
         end
         SC_NUM_E: begin
            if (!fin && digit_c(c)) begin
               lx_len = add_sat(lx_len, 2); lx_mode = SC_EXP; return 1;
            end
            if (!fin && c == "+") begin lx_mode = SC_NUM_EP; return 1; end
            if (!fin && c == "-") begin lx_mode = SC_NUM_EM; return 1; end
            put_token(lx_dot ? K_FLOAT : K_INT, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
            if (!fin && word_start_c(c)) begin
               lx_tok_off = lx_e_off; lx_tok_line = lx_e_line; lx_tok_col = lx_e_col;
               lx_len = 2; lx_mode = SC_IDENT; return 1;
            end
            put_token(K_IDENT, lx_e_line, lx_e_col, lx_e_off, 1);
         end
         SC_NUM_EP, SC_NUM_EM: begin
            if (!fin && digit_c(c)) begin
               lx_len = add_sat(lx_len, 3); lx_mode = SC_EXP; return 1;
            end
            put_token(lx_dot ? K_FLOAT : K_INT, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
            put_token(K_IDENT, lx_e_line, lx_e_col, lx_e_off, 1);
            put_token(m == SC_NUM_EP ? K_PLUS : K_MINUS, lx_e_line, add_sat(lx_e_col, 1),
                      lx_e_off + 1'b1, 1);
         end
         SC_EXP: begin
            if (!fin && digit_c(c)) begin lx_len = add_sat(lx_len, 1); return 1; end
            put_token(K_FLOAT, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
         end
         SC_STR: begin
            if (fin) begin
               put_token(K_ILLEGAL, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
            end else if (c == (lx_quote ? 8'h27 : 8'h22)) begin
               put_token(K_STRING, lx_tok_line, lx_tok_col, lx_tok_off, lx_len);
               lx_mode = SC_IDLE; return 1;
            end else begin
               lx_len = add_sat(lx_len, 1); return 1;
            end
         end
         SC_DOT: begin
            if (!fin && digit_c(c)) begin
               lx_dot = 1; lx_len = 2; lx_mode = SC_NUM; return 1;
            end
            put_token(K_DOT, lx_tok_line, lx_tok_col, lx_tok_off, 1);
         end
         SC_EQ:   begin second = "="; k1 = K_ASSIGN; k2 = K_EQ; end
         SC_STAR: begin second = "*"; k1 = K_STAR; k2 = K_POW; end
         SC_BANG: begin second = "="; k1 = K_BANG; k2 = K_NE; end
         SC_LT:   begin second = "="; k1 = K_LT; k2 = K_LE; end
         SC_GT:   begin second = "="; k1 = K_GT; k2 = K_GE; end
         default: ;
      endcase
      lx_mode = SC_IDLE;
      if (second != 0) begin
         if (!fin && c == second) begin
            put_token(k2, lx_tok_line, lx_tok_col, lx_tok_off, 2); return 1;
         end
         put_token(k1, lx_tok_line, lx_tok_col, lx_tok_off, 1);
      end
      return 0;
   endfunction

   // byte seen between tokens
   task automatic lex_fresh(logic [7:0] c);
      logic [4:0] k;
      bit         single;
      single = 1; k = 0;
      case (c)
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         ",": k = K_COMMA;
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         "[": k = K_LBRACK;
         "]": k = K_RBRACK;
         "/": k = K_SLASH;
         ":": k = K_COLON;
         default: single = 0;
      endcase
      if (single) begin
         put_token(k, lx_line, lx_col, lx_off, 1);
         return;
      end
      case (c)
         "=": begin mark_here(); lx_mode = SC_EQ; end
         "*": begin mark_here(); lx_mode = SC_STAR; end
         "!": begin mark_here(); lx_mode = SC_BANG; end
         "<": begin mark_here(); lx_mode = SC_LT; end
         ">": begin mark_here(); lx_mode = SC_GT; end
         ".": begin mark_here(); lx_mode = SC_DOT; end
         8'h22, 8'h27: begin
            mark_here();
            lx_tok_off = lx_off + 1'b1;
            lx_quote = (c == 8'h27);
            lx_len = 0; lx_mode = SC_STR;
         end
         default: begin
            if (c == " " || (c >= 9 && c <= 13)) begin
            end else if (word_start_c(c)) begin
               mark_here(); lx_len = 1; lx_mode = SC_IDENT;
            end else if (digit_c(c)) begin
               mark_here(); lx_len = 1; lx_dot = 0; lx_mode = SC_NUM;
            end else begin
               put_token(K_ILLEGAL, lx_line, lx_col, lx_off, 1);
            end
         end
      endcase
   endtask

   // model one accepted byte and queue its token records
   task automatic lex_byte(text_item_type it);
      bit fin, used;
      fin = it.end_of_text || it.text_byte == 0;
      lx_out.delete();
      used = lex_pending(it.text_byte, fin);
      if (fin) begin
         put_token(K_END, lx_line, lx_col, lx_off, 0);
         lexer_clear();
      end else begin
         if (!used) lex_fresh(it.text_byte);
         if (it.text_byte == 8'h0a) begin
            lx_line = add_sat(lx_line, 1); lx_col = 1;
         end else begin
            lx_col = add_sat(lx_col, 1);
         end
         lx_off = lx_off + 1'b1;
      end
      if (lx_out.size() > 0) lx_out[lx_out.size()-1].last = 1'b1;
      foreach (lx_out[i]) token_queue.push_back(lx_out[i]);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.text_byte <= '0;
         req_ch.end_of_text <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) lex_byte('{req_ch.text_byte, req_ch.end_of_text});
         if (text_queue.size() > 0 && !(send_idle_ok && $urandom_range(99) < 35)) begin
            req_ch.valid <= 1'b1;
            req_ch.text_byte <= text_queue[0].text_byte;
            req_ch.end_of_text <= text_queue[0].end_of_text;
            void'(text_queue.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result stall control
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(recv_idle_ok && $urandom_range(99) < 35);
      end
   end

   // monitor
   always @(posedge clock) begin
      token_rec_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.token_kind, rsp_ch.first_line, rsp_ch.first_column,
                 rsp_ch.start_offset, rsp_ch.lexeme_length, rsp_ch.last_of_run};
         if (token_queue.size() == 0) begin
            error_count++;
            $display("%0t unexpected token record %p", $time, got);
         end else begin
            want = token_queue.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t token mismatch: expected %p actual %p", $time, want, got);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("expression_text_lexer_top_tb: FAIL");
         $finish;
      end
   end

   task automatic add_text(string s);
      foreach (s[i]) text_queue.push_back('{s[i], 1'b0});
   endtask

   task automatic add_end();
      text_queue.push_back('{8'h00, 1'b1});
   endtask

   task automatic wait_drained();
      while (text_queue.size() > 0 || req_ch.valid || token_queue.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] pick_char();
      string alphabet;
      int    r;
      alphabet = "abzAZ_e Ex09.+-=*!<>()[],/:\"' \n\t";
      r = $urandom_range(99);
      if (r < 8) return $urandom_range(255);
      return alphabet[$urandom_range(alphabet.len() - 1)];
   endfunction

   // fragment with random content, then up to two random bytes and a space
   task automatic add_fragment();
      string s;
      int    n;
      s = "";
      case ($urandom_range(7))
         0: s = $sformatf("x%0d_%c", $urandom_range(999), "a" + $urandom_range(25));
         1: s = $sformatf("%0d.%0de%s%0d", $urandom_range(99), $urandom_range(99),
                          $urandom_range(1) ? "-" : "+", $urandom_range(9));
         2: s = $sformatf("%0d%c", $urandom_range(99), $urandom_range(1) ? "e" : "E");
         3: s = $sformatf("\"s%0d\"", $urandom_range(999));
         4: s = $sformatf("'q %0d'", $urandom_range(99));
         5: s = $urandom_range(1) ? "a<=b" : "c!=d**e";
         6: s = $sformatf(".%0d", $urandom_range(99));
         default: s = $sformatf("%0de-x", $urandom_range(9));
      endcase
      add_text(s);
      n = $urandom_range(2);
      repeat (n) text_queue.push_back('{pick_char(), 1'b0});
      add_text(" ");
   endtask

   int sent;
   int qsize;

   initial begin
      lexer_clear();
      req_ch.valid = 1'b0;
      req_ch.text_byte = '0;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: operators, numbers, rejected exponents, strings, odd bytes
      add_text("a=b==(c)");
      add_text(",+-[]/**!x!=<<=>>=:.5.3e+1 2e-q 3eZ");
      add_text("\n1.2.3 'x' \"y\"");
      text_queue.push_back('{8'hff, 1'b0});
      text_queue.push_back('{8'h80, 1'b0});
      text_queue.push_back('{8'h01, 1'b0});
      add_end();
      add_text("7e+");
      add_end();
      add_text("\"open");
      text_queue.push_back('{8'h00, 1'b0});
      add_text("ab");
      text_queue.push_back('{8'h55, 1'b1});
      wait_drained();

      // long stall at the result side while bytes keep coming
      add_text("1e+ 2e- ( ) [ ] , : / + - ( ) [ ]");
      add_end();
      recv_hold <= 200;
      wait_drained();

      // random fragments and noise
      sent = 0;
      while (sent < 300) begin
         if (sent > 100 && sent < 180) begin
            send_idle_ok = 1'b0; recv_idle_ok = 1'b0;
         end else begin
            send_idle_ok = 1'b1; recv_idle_ok = 1'b1;
         end
         qsize = text_queue.size();
         if ($urandom_range(99) < 70) add_fragment();
         else repeat ($urandom_range(1, 4)) text_queue.push_back('{pick_char(), 1'b0});
         if ($urandom_range(99) < 8) add_end();
         sent = sent + text_queue.size() - qsize;
         while (text_queue.size() > 8) @(posedge clock);
      end
      add_end();
      wait_drained();
      repeat (20) @(posedge clock);

      if (error_count == 0 && token_queue.size() == 0) begin
         $display("expression_text_lexer_top_tb: PASS");
      end else begin
         $display("expression_text_lexer_top_tb: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
